// ===== rtl/core/four_level_page_table_walker_core_macros.svh =====
// assertion macros used by the page table walker controller
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH

// condition must hold on every cycle out of reset
`define PTW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define PTW_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/core/ptw_pkg.sv =====
// shared types and constants of the page table walker
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

  // default table memory depth in 64-bit words
  localparam int unsigned MEM_WORDS_DEFAULT = 4096;

  // status codes of a result
  localparam logic [1:0] STATUS_DONE   = 2'd0;
  localparam logic [1:0] STATUS_NOTMAP = 2'd1;
  localparam logic [1:0] STATUS_WINDOW = 2'd2;

  // request operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_XLATE = 2'd1,
    OP_UNMAP = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // kind of result loaded into the output register
  typedef enum logic [1:0] {
    RES_DONE,
    RES_NOTMAP,
    RES_WINDOW,
    RES_XLATED
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic write_word;
    logic clear_slot;
    logic read;
    logic descend;
    logic out_load;
    res_t res;
  } ptw_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic wa_ok;
    logic slot_ok;
    logic leaf;
    logic present;
    logic huge;
    logic clr_last;
  } ptw_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ptw_dpath.sv =====
// datapath of the page table walker: table memory, walk registers, result register
`timescale 1ns / 1ps
`default_nettype none

module ptw_dpath
  import ptw_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [62:0] root_table_base,
  input  wire logic [1:0]  op,
  input  wire logic [47:0] virt_addr,
  input  wire logic [11:0] word_addr,
  input  wire logic [63:0] entry_data,
  input  wire ptw_cmd_t    cmd,
  output ptw_stat_t        st,
  output logic [62:0]      phys_addr,
  output logic [1:0]       status,
  output logic [1:0]       page_level
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  logic [63:0]   mem [MEM_WORDS];
  logic [62:0]   root_base;
  op_t           op_q;
  logic [47:0]   va_q;
  logic [11:0]   wa_q;
  logic [63:0]   data_q;
  logic [50:0]   tab;
  logic [1:0]    lvl;
  logic [AW-1:0] clr_addr;
  logic [63:0]   rd_data;

  logic [8:0]    idx;
  logic [59:0]   slot;
  logic [AW-1:0] slot_idx;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [63:0]   mem_wdata;
  logic [62:0]   xlat;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      root_base <= '0;
    end else if (cfg_valid) begin
      root_base <= root_table_base;
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // request capture and walk pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op_t'(op);
      va_q   <= virt_addr;
      wa_q   <= word_addr;
      data_q <= entry_data;
      tab    <= root_base[62:12];
      lvl    <= 2'd3;
    end else if (cmd.descend) begin
      tab <= rd_data[62:12];
      lvl <= lvl - 2'd1;
    end
  end

  // level index; tables are 4K aligned so the slot is a concatenation
  always_comb begin
    case (lvl)
      2'd3:    idx = va_q[47:39];
      2'd2:    idx = va_q[38:30];
      2'd1:    idx = va_q[29:21];
      default: idx = va_q[20:12];
    endcase
  end

  assign slot     = {tab, idx};
  assign slot_idx = slot[AW-1:0];

  // memory write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_idx;
    mem_wdata = '0;
    if (cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
    end else if (cmd.write_word) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(wa_q);
      mem_wdata = data_q;
    end else if (cmd.clear_slot) begin
      mem_we    = 1'b1;
    end
  end

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.read) begin
      rd_data <= mem[slot_idx];
    end
  end

  // translated address: entry frame with the page offset from the request
  always_comb begin
    case (lvl)
      2'd3:    xlat = {rd_data[62:39], va_q[38:0]};
      2'd2:    xlat = {rd_data[62:30], va_q[29:0]};
      2'd1:    xlat = {rd_data[62:21], va_q[20:0]};
      default: xlat = {rd_data[62:12], va_q[11:0]};
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.res)
        RES_XLATED: begin
          phys_addr  <= xlat;
          page_level <= lvl;
          status     <= STATUS_DONE;
        end
        RES_DONE: begin
          phys_addr  <= '0;
          page_level <= '0;
          status     <= STATUS_DONE;
        end
        RES_WINDOW: begin
          phys_addr  <= '0;
          page_level <= '0;
          status     <= STATUS_WINDOW;
        end
        default: begin
          phys_addr  <= '0;
          page_level <= '0;
          status     <= STATUS_NOTMAP;
        end
      endcase
    end
  end

  // status to the controller
  assign st.op       = op_q;
  assign st.wa_ok    = 64'(wa_q) < 64'(MEM_WORDS);
  assign st.slot_ok  = slot < 60'(MEM_WORDS);
  assign st.leaf     = (lvl == 2'd0);
  assign st.present  = rd_data[0];
  assign st.huge     = rd_data[7];
  assign st.clr_last = (clr_addr == AW'(MEM_WORDS - 1));

endmodule

`default_nettype wire

// ===== rtl/core/ptw_ctrl.sv =====
// controller of the page table walker: clearing pass, walk sequencing, result handoff
`timescale 1ns / 1ps
`default_nettype none
`include "four_level_page_table_walker_core_macros.svh"

module ptw_ctrl
  import ptw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire ptw_stat_t st,
  output ptw_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ISSUE,
    S_CHECK
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res    = RES_NOTMAP;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        unique case (st.op) inside
          OP_WRITE: begin
            if (out_free) begin
              cmd.write_word = st.wa_ok;
              cmd.out_load   = 1'b1;
              cmd.res        = st.wa_ok ? RES_DONE : RES_NOTMAP;
              state_next     = S_IDLE;
            end
          end
          OP_XLATE, OP_UNMAP: begin
            if (!st.slot_ok) begin
              if (out_free) begin
                cmd.out_load = 1'b1;
                cmd.res      = RES_WINDOW;
                state_next   = S_IDLE;
              end
            end else if (st.leaf && st.op == OP_UNMAP) begin
              if (out_free) begin
                cmd.clear_slot = 1'b1;
                cmd.out_load   = 1'b1;
                cmd.res        = RES_DONE;
                state_next     = S_IDLE;
              end
            end else begin
              cmd.read   = 1'b1;
              state_next = S_CHECK;
            end
          end
          default: begin
            if (out_free) begin
              cmd.out_load = 1'b1;
              cmd.res      = RES_NOTMAP;
              state_next   = S_IDLE;
            end
          end
        endcase
      end
      S_CHECK: begin
        if (!st.present) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            cmd.res      = RES_NOTMAP;
            state_next   = S_IDLE;
          end
        end else if (!st.leaf && st.huge) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            cmd.res      = (st.op == OP_UNMAP) ? RES_NOTMAP : RES_XLATED;
            state_next   = S_IDLE;
          end
        end else if (!st.leaf) begin
          cmd.descend = 1'b1;
          state_next  = S_ISSUE;
        end else if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.res      = RES_XLATED;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // checks
  `PTW_ASSERT_IMPLIES(a_load_free, cmd.out_load, !out_valid || out_ready, "result overwritten")
  `PTW_ASSERT_IMPLIES(a_descend_leaf, cmd.descend, !st.leaf, "descend past the last level")
  `PTW_ASSERT_IMPLIES(a_unmap_slot, cmd.clear_slot, st.slot_ok && st.leaf, "unmap outside window")
  `PTW_ASSERT_ALWAYS(a_one_write, $onehot0({cmd.clear, cmd.write_word, cmd.clear_slot}), "write clash")

endmodule

`default_nettype wire

// ===== rtl/core/four_level_page_table_walker_core.sv =====
// top level of the four-level page table walker. After reset the table memory is
// cleared one word per cycle, all MEM_WORDS words (4096 by default), and in_ready stays
// low until that pass ends; the root register can be written at any time. A table
// write or an unknown op is captured in S_IDLE and answered from S_ISSUE, which loads
// the output register and raises out_valid once that register is free. A translate
// visits S_ISSUE (slot address and memory read), then S_CHECK (entry check on the
// registered read data) for each level until the walk ends; an unmap does the same
// but clears a leaf slot straight from S_ISSUE. Each result waits for a free output
// register. One request is in flight at a time, and a finished result waits in the
// output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module four_level_page_table_walker_core
  import ptw_pkg::*;
#(
  parameter int unsigned MEM_WORDS = MEM_WORDS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [62:0] root_table_base,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  op,
  input  wire logic [47:0] virt_addr,
  input  wire logic [11:0] word_addr,
  input  wire logic [63:0] entry_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [62:0]      phys_addr,
  output logic [1:0]       status,
  output logic [1:0]       page_level
);

  ptw_cmd_t  cmd;
  ptw_stat_t st;

  // the root register takes a write on any cycle
  assign cfg_ready = 1'b1;

  // sequencing
  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // memory and walk registers
  ptw_dpath #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .root_table_base (root_table_base),
    .op              (op),
    .virt_addr       (virt_addr),
    .word_addr       (word_addr),
    .entry_data      (entry_data),
    .cmd             (cmd),
    .st              (st),
    .phys_addr       (phys_addr),
    .status          (status),
    .page_level      (page_level)
  );

endmodule

`default_nettype wire
